/* hdl/link_utilization_monitor_macros.svh */
// Assertion macros shared by the link utilisation monitor RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LINK_UTILIZATION_MONITOR_MACROS_SVH
`define LINK_UTILIZATION_MONITOR_MACROS_SVH
`ifndef SYNTH
`define LUM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link utilisation monitor: implication check failed");
`define LUM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link utilisation monitor: next-cycle check failed");
`else
`define LUM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LUM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/lum_pkg.sv */
// Package for the link utilisation monitor: widths, constants, codes, states.
// No dependencies.
`timescale 1ns / 1ps
package lum_pkg;
   localparam int MAX_RECORDS = 16;
   localparam int SLOT_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int UTIL_W      = 17;
   localparam int TICK_W      = 48;
   localparam int WEIGHT_W    = 32;
   localparam int RIU_W       = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int OP_W        = 2;
   localparam int SQUARINGS   = 12;
   localparam int QUOT_W      = 17;

   localparam logic [UTIL_W-1:0] FULL_UTIL   = 17'd65536;
   localparam logic [32:0]       ONE_Q32     = 33'h1_0000_0000;
   localparam logic [65:0]       HP_LIMIT    = 66'd6144;
   localparam logic [56:0]       EXP_LIMIT   = 57'd24 << 32;
   localparam logic [15:0]       DIV6_RECIP  = 16'd43691;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_WEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORDS_IN_USE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED       = 2'd3;

   localparam logic [OP_W-1:0] OP_SET_STATE  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY_AVG  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY_PEAK = 2'd2;
   localparam logic [OP_W-1:0] OP_UNDEFINED  = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SPAN, ST_HP, ST_HPCHK, ST_XLO, ST_X, ST_Y2, ST_Y3, ST_P,
      ST_SQ, ST_SQN, ST_AVG, ST_AVGW, ST_NORM, ST_MLO, ST_MHI, ST_NUM,
      ST_DIV, ST_REC, ST_COMMIT, ST_SCAN, ST_DRAIN, ST_DONE
   } state_type;
endpackage

/* hdl/lum_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on lum_pkg.
`timescale 1ns / 1ps
interface lum_req_if import lum_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [TICK_W-1:0] now_tick;
   logic              new_busy;
   modport source (output valid, op, now_tick, new_busy, input ready);
   modport sink (input valid, op, now_tick, new_busy, output ready);
endinterface

interface lum_rsp_if import lum_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [UTIL_W-1:0] avg_util;
   logic [UTIL_W-1:0] peak_util;
   modport source (output valid, avg_util, peak_util, input ready);
   modport sink (input valid, avg_util, peak_util, output ready);
endinterface

/* hdl/lum_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lum_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/link_utilization_monitor.sv */
// Link utilisation monitor top level: decayed average, period mean, peak ring.
// Depends on lum_pkg, lum_if, lum_ram and link_utilization_monitor_macros.svh.
//
//   channel | direction | payload
//   req     | in        | op, now_tick, new_busy
//   rsp     | out       | avg_util, peak_util
//   csr     | in        | write enable, index, 32-bit data
//
// From acceptance to response a request may pass through the twelve squarings of
// the decay factor on the shared 33x33 multiplier, normalisation of the mean
// weights, the bit-serial mean divider (17 quotient bits), peak record writes and
// a scan of the records. The next request is taken only once the block is idle again.
// Reset is synchronous and resets the control state; peak records read as zero until
// written. A stalled response holds the block in its final state.
`timescale 1ns / 1ps
`include "link_utilization_monitor_macros.svh"
module link_utilization_monitor import lum_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lum_req_if.sink              req_chan,
   lum_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WEIGHT_W-1:0]  csr_wdata
);
   state_type state_ff, state_in;

   logic [WEIGHT_W-1:0] decay_weight_ff, check_interval_ff;
   logic [RIU_W-1:0]    records_in_use_ff;
   logic                link_busy_ff, link_busy_in;
   logic [TICK_W-1:0]   last_change_ff, last_change_in;
   logic [TICK_W-1:0]   period_start_ff, period_start_in;
   logic [UTIL_W-1:0]   avg_ff, avg_in, mean_ff, mean_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [MAX_RECORDS-1:0] valid_ff, valid_in;

   logic [OP_W-1:0]     op_ff;
   logic [TICK_W-1:0]   now_ff;
   logic                new_busy_ff;
   logic [TICK_W-1:0]   span_ff, span_in, prev_ff, prev_in;
   logic [12:0]         hp_ff, hp_in;
   logic [24:0]         y_ff, y_in;
   logic [17:0]         y2_ff, y2_in;
   logic [32:0]         p_ff, p_in;
   logic [3:0]          sq_cnt_ff, sq_cnt_in;
   logic [65:0]         prod_ff;
   logic [TICK_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [48:0]         acc_ff, acc_in;
   logic [45:0]         rem_ff, rem_in, d_ff, d_in;
   logic [16:0]         numlo_ff, numlo_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [4:0]          div_cnt_ff, div_cnt_in;
   logic signed [49:0]  t_ff, t_in;
   logic [CNT_W-1:0]    guard_ff, guard_in, scan_cnt_ff, scan_cnt_in;
   logic                pend_ff, pend_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [UTIL_W-1:0]   peak_ff, peak_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [UTIL_W-1:0]   rsp_avg_ff, rsp_avg_in, rsp_peak_ff, rsp_peak_in;

   logic [32:0]         mul_a, mul_b;
   logic [65:0]         mul_p;
   logic                req_take;
   logic [CNT_W-1:0]    rec_count;
   logic [UTIL_W-1:0]   target;
   logic [TICK_W-1:0]   span_calc, prev_calc;
   logic [56:0]         x_calc, x_round;
   logic [26:0]         div6_prod;
   logic [UTIL_W-1:0]   diff_calc, delta_calc;
   logic                avg_ge;
   logic [48:0]         ab_sum;
   logic [62:0]         num_calc;
   logic [46:0]         rem_shift;
   logic                div_bit;
   logic                rec_take;
   logic [UTIL_W-1:0]   rec_val;
   logic                ram_wr_en;
   logic [UTIL_W-1:0]   ram_rd_data;
   logic                out_free;
   logic                csr_riu_wr;

   assign req_take  = req_chan.valid && req_chan.ready;
   assign csr_riu_wr = csr_wr_en && (csr_index == CSR_RECORDS_IN_USE);
   assign rec_count = (records_in_use_ff > RIU_W'(MAX_RECORDS)) ? CNT_W'(MAX_RECORDS)
                                                                : CNT_W'(records_in_use_ff);
   assign target    = link_busy_ff ? FULL_UTIL : '0;
   assign span_calc = (now_ff >= last_change_ff) ? now_ff - last_change_ff : '0;
   assign prev_calc = (last_change_ff >= period_start_ff) ?
                      last_change_ff - period_start_ff : '0;
   assign x_calc    = {20'd0, hp_ff, 24'd0} + prod_ff[56:0];
   assign x_round   = x_calc + 57'd2048;
   assign div6_prod = 27'(prod_ff[42:32]) * 27'(DIV6_RECIP);
   assign avg_ge    = avg_ff >= target;
   assign diff_calc = avg_ge ? avg_ff - target : target - avg_ff;
   assign delta_calc = prod_ff[48:32];
   assign ab_sum    = {1'b0, a_ff} + {1'b0, b_ff};
   assign num_calc  = (link_busy_ff ? {a_ff[45:0], 17'd0} >> 1 : 63'd0)
                      + {14'd0, acc_ff} + {prod_ff[30:0], 32'd0};
   assign rem_shift = {rem_ff, numlo_ff[16]};
   assign div_bit   = rem_shift >= {1'b0, d_ff};
   assign rec_take  = (t_ff > $signed({18'd0, check_interval_ff})) && (guard_ff < rec_count);
   assign ram_wr_en = (state_ff == ST_REC) && rec_take;
   assign rec_val   = valid_ff[idx_ff] ? ram_rd_data : '0;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign mul_p     = 66'(mul_a) * 66'(mul_b);

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.avg_util  = rsp_avg_ff;
   assign rsp_chan.peak_util = rsp_peak_ff;

   lum_ram #(.WIDTH(UTIL_W), .DEPTH(MAX_RECORDS)) u_peak_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (mean_ff),
      .rd_addr (scan_cnt_ff[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      unique case (state_ff)
         ST_Y2:   begin mul_a = 33'(y_ff);       mul_b = 33'(y_ff); end
         ST_Y3:   begin mul_a = 33'(prod_ff[49:32]); mul_b = 33'(y_ff); end
         ST_SQ:   begin mul_a = p_ff;            mul_b = p_ff; end
         ST_AVG:  begin mul_a = 33'(diff_calc);  mul_b = p_ff; end
         ST_MLO:  begin mul_a = 33'(mean_ff);    mul_b = 33'(b_ff[31:0]); end
         ST_MHI:  begin mul_a = 33'(mean_ff);    mul_b = 33'(b_ff[45:32]); end
         ST_XLO:  begin mul_a = 33'(decay_weight_ff); mul_b = 33'(span_ff[23:0]); end
         default: begin mul_a = 33'(decay_weight_ff); mul_b = 33'(span_ff[47:24]); end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_SPAN;
         ST_SPAN:  state_in = (decay_weight_ff == '0 || span_calc == '0) ? ST_AVG : ST_HP;
         ST_HP:    state_in = ST_HPCHK;
         ST_HPCHK: state_in = (prod_ff > HP_LIMIT) ? ST_AVG : ST_XLO;
         ST_XLO:   state_in = ST_X;
         ST_X:     state_in = (x_calc >= EXP_LIMIT || x_round[56:12] == '0) ? ST_AVG : ST_Y2;
         ST_Y2:    state_in = ST_Y3;
         ST_Y3:    state_in = ST_P;
         ST_P:     state_in = ST_SQ;
         ST_SQ:    state_in = ST_SQN;
         ST_SQN:   state_in = (sq_cnt_ff == 4'd1) ? ST_AVG : ST_SQ;
         ST_AVG:   state_in = ST_AVGW;
         ST_AVGW: begin
            if (rec_count == '0 || (span_ff == '0 && prev_ff == '0)) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM:  if (ab_sum[48:46] == '0) state_in = ST_MLO;
         ST_MLO:   state_in = ST_MHI;
         ST_MHI:   state_in = ST_NUM;
         ST_NUM:   state_in = ST_DIV;
         ST_DIV:   if (div_cnt_ff == 5'd1) state_in = ST_REC;
         ST_REC:   if (!rec_take) state_in = ST_COMMIT;
         ST_COMMIT: state_in = (rec_count == '0) ? ST_DONE : ST_SCAN;
         ST_SCAN:  if (scan_cnt_ff == rec_count - 1'b1) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      link_busy_in    = link_busy_ff;
      last_change_in  = last_change_ff;
      period_start_in = period_start_ff;
      avg_in          = avg_ff;
      mean_in         = mean_ff;
      slot_in         = slot_ff;
      valid_in        = valid_ff;
      span_in         = span_ff;
      prev_in         = prev_ff;
      hp_in           = hp_ff;
      y_in            = y_ff;
      y2_in           = y2_ff;
      p_in            = p_ff;
      sq_cnt_in       = sq_cnt_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      acc_in          = acc_ff;
      rem_in          = rem_ff;
      d_in            = d_ff;
      numlo_in        = numlo_ff;
      quot_in         = quot_ff;
      div_cnt_in      = div_cnt_ff;
      t_in            = t_ff;
      guard_in        = guard_ff;
      scan_cnt_in     = scan_cnt_ff;
      pend_in         = 1'b0;
      idx_in          = idx_ff;
      peak_in         = peak_ff;
      rsp_avg_in      = rsp_avg_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_SPAN: begin
            span_in = span_calc;
            prev_in = prev_calc;
            p_in    = ONE_Q32;
         end
         ST_HPCHK: begin
            hp_in = prod_ff[12:0];
            if (prod_ff > HP_LIMIT) p_in = '0;
         end
         ST_X: begin
            y_in = x_round[36:12];
            if (x_calc >= EXP_LIMIT) p_in = '0;
         end
         ST_Y3: y2_in = prod_ff[49:32];
         ST_P: begin
            p_in = ONE_Q32 - 33'(y_ff) + 33'(y2_ff[17:1]) - 33'(div6_prod[26:18]);
            sq_cnt_in = 4'(SQUARINGS);
         end
         ST_SQN: begin
            p_in = prod_ff[64:32];
            sq_cnt_in = sq_cnt_ff - 1'b1;
         end
         ST_AVGW: begin
            avg_in = avg_ge ? target + delta_calc : target - delta_calc;
            if (rec_count != '0 && CNT_W'(slot_ff) >= rec_count) slot_in = '0;
            a_in = span_ff;
            b_in = prev_ff;
         end
         ST_NORM: begin
            if (ab_sum[48:46] != '0) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
            end
         end
         ST_MHI: acc_in = prod_ff[48:0];
         ST_NUM: begin
            rem_in     = num_calc[62:17];
            numlo_in   = num_calc[16:0];
            d_in       = ab_sum[45:0];
            quot_in    = '0;
            div_cnt_in = 5'(QUOT_W);
         end
         ST_DIV: begin
            rem_in     = div_bit ? 46'(rem_shift - {1'b0, d_ff}) : rem_shift[45:0];
            numlo_in   = numlo_ff << 1;
            quot_in    = {quot_ff[QUOT_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == 5'd1) begin
               mean_in  = {quot_ff[QUOT_W-2:0], div_bit};
               t_in     = $signed({2'd0, prev_ff}) + $signed({2'd0, span_ff});
               guard_in = '0;
            end
         end
         ST_REC: begin
            if (rec_take) begin
               valid_in[slot_ff] = 1'b1;
               slot_in  = (CNT_W'(slot_ff) + 1'b1 >= rec_count) ? '0 : slot_ff + 1'b1;
               mean_in  = target;
               period_start_in = now_ff;
               t_in     = t_ff - $signed({18'd0, check_interval_ff});
               guard_in = guard_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            last_change_in = now_ff;
            if (op_ff == OP_SET_STATE) link_busy_in = new_busy_ff;
            peak_in     = (rec_count == '0) ? avg_ff : '0;
            scan_cnt_in = '0;
         end
         ST_SCAN: begin
            pend_in     = 1'b1;
            idx_in      = scan_cnt_ff[SLOT_W-1:0];
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (pend_ff && rec_val > peak_ff) peak_in = rec_val;
         end
         ST_DRAIN: if (rec_val > peak_ff) peak_in = rec_val;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_peak_in  = peak_ff;
            end
         end
         default: begin
         end
      endcase
      if (csr_riu_wr) begin
         valid_in = '0;
         slot_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         decay_weight_ff   <= '0;
         check_interval_ff <= 32'd1;
         records_in_use_ff <= '0;
         link_busy_ff      <= 1'b0;
         last_change_ff    <= '0;
         period_start_ff   <= '0;
         avg_ff            <= '0;
         mean_ff           <= '0;
         slot_ff           <= '0;
         valid_ff          <= '0;
         pend_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         link_busy_ff    <= link_busy_in;
         last_change_ff  <= last_change_in;
         period_start_ff <= period_start_in;
         avg_ff          <= avg_in;
         mean_ff         <= mean_in;
         slot_ff         <= slot_in;
         valid_ff        <= valid_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DECAY_WEIGHT:   decay_weight_ff   <= csr_wdata;
               CSR_CHECK_INTERVAL: check_interval_ff <= csr_wdata;
               CSR_RECORDS_IN_USE: records_in_use_ff <= csr_wdata[RIU_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= req_chan.op;
         now_ff      <= req_chan.now_tick;
         new_busy_ff <= req_chan.new_busy;
      end
      prod_ff     <= mul_p;
      span_ff     <= span_in;
      prev_ff     <= prev_in;
      hp_ff       <= hp_in;
      y_ff        <= y_in;
      y2_ff       <= y2_in;
      p_ff        <= p_in;
      sq_cnt_ff   <= sq_cnt_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      d_ff        <= d_in;
      numlo_ff    <= numlo_in;
      quot_ff     <= quot_in;
      div_cnt_ff  <= div_cnt_in;
      t_ff        <= t_in;
      guard_ff    <= guard_in;
      scan_cnt_ff <= scan_cnt_in;
      idx_ff      <= idx_in;
      peak_ff     <= peak_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_peak_ff <= rsp_peak_in;
   end

   `LUM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_take, state_ff != ST_IDLE)
   `LUM_ASSERT_IMPL(a_record_write_bounded, clock, reset, ram_wr_en, guard_ff < rec_count)
   `LUM_ASSERT_IMPL(a_scan_needs_records, clock, reset, state_ff == ST_SCAN, rec_count != '0)
   `LUM_ASSERT_NEXT(a_count_write_clears, clock, reset, csr_riu_wr, valid_ff == '0 && slot_ff == '0)
endmodule
